// ----- rtl/core/sel_pkg.sv -----
package sel_pkg;

	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_VOLUME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd2;

	localparam logic [CFG_W-1:0] VOLUME_RST  = 16'd16384;
	localparam logic [CFG_W-1:0] ATTACK_RST  = 16'd65365;
	localparam logic [CFG_W-1:0] RELEASE_RST = 16'd65365;
	localparam logic [CFG_W-1:0] VOL_MAX     = 16'd32768;
	localparam logic [CFG_W-1:0] GAIN_095    = 16'd62259;

	localparam int LIM_W   = 31;
	localparam int GAIN_W  = 30;
	localparam int VAL_W   = 32;
	localparam int ENV_W   = 32;
	localparam int DIFF_W  = 33;
	localparam int ER_W    = 34;
	localparam int DIV_D_W = 32;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = 66;

	localparam int COEF_SHIFT = 16;
	localparam int Q30_SHIFT  = 30;

	localparam logic [DIFF_W-1:0] ONE_Q30 = 33'h040000000;

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_LIM  = 18'h00002,
		S_GAIN = 18'h00004,
		S_GRND = 18'h00008,
		S_V0   = 18'h00010,
		S_V1   = 18'h00020,
		S_V1R  = 18'h00040,
		S_PEAK = 18'h00080,
		S_EMUL = 18'h00100,
		S_ENV  = 18'h00200,
		S_ABS  = 18'h00400,
		S_SEL  = 18'h00800,
		S_PASS = 18'h01000,
		S_DLGO = 18'h02000,
		S_DLW  = 18'h04000,
		S_DRGO = 18'h08000,
		S_DRW  = 18'h10000,
		S_OUT  = 18'h20000
	} state_t;

	typedef struct packed {
		logic start;
		logic neg;
		logic num_zero;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic clip;
	} div_rsp_t;

endpackage

// ----- rtl/core/sel_mul.sv -----
module sel_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [sel_pkg::MUL_A_W-1:0] a,
	input  logic signed [sel_pkg::MUL_B_W-1:0] b,
	output logic signed [sel_pkg::MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

// ----- rtl/core/sel_div.sv -----
module sel_div #(
	parameter int SAMPLE_BITS = sel_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sel_pkg::div_req_t                  req,
	input  logic [sel_pkg::GAIN_W+SAMPLE_BITS-2:0] num,
	input  logic [sel_pkg::DIV_D_W-1:0]        den,
	output sel_pkg::div_rsp_t                  rsp,
	output logic signed [SAMPLE_BITS-1:0]      res
);

	localparam int F  = SAMPLE_BITS - 1;
	localparam int QW = F + 2;
	localparam int SW = sel_pkg::DIV_D_W + F + 1;
	localparam int CW = $clog2(QW);

	localparam logic [QW-1:0] POS_MAX = {2'b00, {F{1'b1}}};
	localparam logic [QW-1:0] NEG_MAX = {2'b01, {F{1'b0}}};
	localparam logic [SAMPLE_BITS-1:0] OUT_HI = {1'b0, {F{1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] OUT_LO = {1'b1, {F{1'b0}}};

	logic          busy_q;
	logic          fin_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic          neg_q;
	logic          zero_q;
	logic          ge;
	logic [SW-1:0] diff;

	assign ge   = rem_q >= dsh_q;
	assign diff = rem_q - dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= SW'(num);
			dsh_q  <= {den, {(F + 1){1'b0}}};
			quo_q  <= '0;
			neg_q  <= req.neg;
			zero_q <= req.num_zero;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	// sign and saturation of the finished quotient
	always_comb begin
		rsp.done = fin_q;
		res      = '0;
		rsp.clip = 1'b0;
		if (zero_q) begin
			res = '0;
		end else if (neg_q) begin
			if (quo_q > NEG_MAX) begin
				res      = OUT_LO;
				rsp.clip = 1'b1;
			end else begin
				res = -quo_q[SAMPLE_BITS-1:0];
			end
		end else begin
			if (quo_q > POS_MAX) begin
				res      = OUT_HI;
				rsp.clip = 1'b1;
			end else begin
				res = quo_q[SAMPLE_BITS-1:0];
			end
		end
	end

endmodule

// ----- rtl/core/stereo_envelope_limiter.sv -----
// flow: an accepted item steps through LIM, GAIN, GRND, V0, V1, V1R, PEAK, EMUL, ENV, ABS,
// SEL, then PASS while the envelope is within the limit, else DLGO to DRW with both samples
// through the divider, then OUT; a new item is taken only in IDLE, so the shared multiplier
// sequence and the bit-serial divider (SAMPLE_BITS+1 steps per channel) set the throughput
// reset: arst_n asynchronous active low, clears the envelope, the registers to their
// defaults and all handshake state
module stereo_envelope_limiter #(
	parameter int SAMPLE_BITS = sel_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// left_sample, right_sample
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// left_out, right_out
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	// clipped
	output logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic [sel_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [sel_pkg::CFG_W-1:0]         cfg_data
);

	localparam int SB  = SAMPLE_BITS;
	localparam int F   = SB - 1;
	localparam int TDW = ((2 * SB + 7) / 8) * 8;
	localparam int NW  = sel_pkg::GAIN_W + F;
	localparam int PW  = sel_pkg::VAL_W + F;
	localparam int PB  = sel_pkg::MUL_P_W;

	localparam logic [PB-1:0] COEF_HALF = PB'(1) << (sel_pkg::COEF_SHIFT - 1);
	localparam logic [PB-1:0] V_HALF    = PB'(1) << (F - 1);

	sel_pkg::state_t state_q, state_d;

	logic [sel_pkg::CFG_W-1:0] volume_q, attack_q, release_q;
	logic [sel_pkg::CFG_W-1:0] vol_c;

	logic signed [SB-1:0]                   s0_q, s1_q;
	logic [sel_pkg::LIM_W-1:0]              limit_q;
	logic [sel_pkg::GAIN_W-1:0]             gain_q;
	logic signed [sel_pkg::VAL_W-1:0]       v0_q, v1_q, peak_q;
	logic [sel_pkg::CFG_W-1:0]              coef_q;
	logic signed [sel_pkg::DIFF_W-1:0]      d_q;
	logic signed [sel_pkg::ENV_W-1:0]       env_q;
	logic [sel_pkg::DIFF_W-1:0]             abs_q;
	logic [sel_pkg::DIV_D_W-1:0]            div_mag_q;
	logic                                   div_neg_q;
	logic [SB-1:0]                          o0_q, o1_q;
	logic                                   clip_q;
	logic [SB-1:0]                          out_l_q, out_r_q;
	logic                                   out_clip_q;
	logic                                   m_valid_q;

	logic                                   mul_en;
	logic signed [sel_pkg::MUL_A_W-1:0]     mul_a;
	logic signed [sel_pkg::MUL_B_W-1:0]     mul_b;
	logic signed [PB-1:0]                   prod_q;

	logic [PB-1:0]                          gsum, vsum, esum;
	logic [sel_pkg::GAIN_W-1:0]             gain_c;
	logic signed [sel_pkg::VAL_W-1:0]       v_c, peak_c, v_sel;
	logic signed [sel_pkg::ER_W-1:0]        er_c;
	logic signed [sel_pkg::ER_W:0]          esat_sum;
	logic signed [sel_pkg::ENV_W-1:0]       env_c;
	logic [sel_pkg::DIFF_W:0]               divisor;
	logic                                   big_c, use_env;
	logic [sel_pkg::VAL_W-1:0]              vmag;
	logic [SB:0]                            p0_c, p1_c;
	logic                                   accept, out_free;

	sel_pkg::div_req_t                      div_req;
	sel_pkg::div_rsp_t                      div_rsp;
	logic [NW-1:0]                          div_num;
	logic signed [SB-1:0]                   div_res;

	function automatic logic [SB:0] pass_out(input logic signed [sel_pkg::VAL_W-1:0] v);
		logic signed [PW-1:0] x;
		logic [SB:0]          r;
		logic [SB:0]          o;
		x = (PW'(v) <<< F) + (PW'(1) <<< (sel_pkg::Q30_SHIFT - 1));
		r = x[PW-1:sel_pkg::Q30_SHIFT];
		if (r[SB] != r[SB-1]) begin
			o = {1'b1, r[SB] ? {1'b1, {F{1'b0}}} : {1'b0, {F{1'b1}}}};
		end else begin
			o = {1'b0, r[SB-1:0]};
		end
		return o;
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == sel_pkg::S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDW'({out_r_q, out_l_q});
	assign m_tuser  = out_clip_q;

	assign vol_c = (volume_q > sel_pkg::VOL_MAX) ? sel_pkg::VOL_MAX : volume_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			sel_pkg::S_LIM: begin
				mul_a = sel_pkg::MUL_A_W'(vol_c);
				mul_b = sel_pkg::MUL_B_W'(vol_c);
			end
			sel_pkg::S_GAIN: begin
				mul_a = sel_pkg::MUL_A_W'(prod_q[sel_pkg::LIM_W-1:0]);
				mul_b = sel_pkg::MUL_B_W'(sel_pkg::GAIN_095);
			end
			sel_pkg::S_V0: begin
				mul_a = sel_pkg::MUL_A_W'(s0_q);
				mul_b = sel_pkg::MUL_B_W'(gain_q);
			end
			sel_pkg::S_V1: begin
				mul_a = sel_pkg::MUL_A_W'(s1_q);
				mul_b = sel_pkg::MUL_B_W'(gain_q);
			end
			sel_pkg::S_EMUL: begin
				mul_a = sel_pkg::MUL_A_W'(d_q);
				mul_b = sel_pkg::MUL_B_W'(coef_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	sel_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	// rounding of the product register
	assign gsum   = prod_q + COEF_HALF;
	assign gain_c = gsum[sel_pkg::COEF_SHIFT+sel_pkg::GAIN_W-1:sel_pkg::COEF_SHIFT];
	assign vsum   = prod_q + V_HALF;
	assign v_c    = vsum[F+sel_pkg::VAL_W-1:F];
	assign esum   = prod_q + COEF_HALF;
	assign er_c   = esum[sel_pkg::COEF_SHIFT+sel_pkg::ER_W-1:sel_pkg::COEF_SHIFT];

	assign esat_sum = (sel_pkg::ER_W + 1)'(er_c) + (sel_pkg::ER_W + 1)'(peak_q);
	always_comb begin
		if (esat_sum[sel_pkg::ER_W:sel_pkg::ENV_W-1] == '0
				|| esat_sum[sel_pkg::ER_W:sel_pkg::ENV_W-1] == '1) begin
			env_c = esat_sum[sel_pkg::ENV_W-1:0];
		end else if (esat_sum[sel_pkg::ER_W]) begin
			env_c = {1'b1, {(sel_pkg::ENV_W - 1){1'b0}}};
		end else begin
			env_c = {1'b0, {(sel_pkg::ENV_W - 1){1'b1}}};
		end
	end

	assign peak_c  = (v0_q > v1_q) ? v0_q : v1_q;
	assign big_c   = abs_q > sel_pkg::DIFF_W'(limit_q);
	assign use_env = abs_q > sel_pkg::ONE_Q30;
	assign divisor = use_env ? (sel_pkg::DIFF_W + 1)'(env_q)
		: (sel_pkg::DIFF_W + 1)'(env_q) + (sel_pkg::DIFF_W + 1)'(sel_pkg::ONE_Q30)
		- (sel_pkg::DIFF_W + 1)'(limit_q);

	assign p0_c = pass_out(v0_q);
	assign p1_c = pass_out(v1_q);

	// divider request
	assign v_sel            = (state_q == sel_pkg::S_DRGO) ? v1_q : v0_q;
	assign vmag             = v_sel[sel_pkg::VAL_W-1] ? -v_sel : v_sel;
	assign div_num          = {vmag[sel_pkg::GAIN_W-1:0], {F{1'b0}}};
	assign div_req.start    = (state_q == sel_pkg::S_DLGO) || (state_q == sel_pkg::S_DRGO);
	assign div_req.neg      = v_sel[sel_pkg::VAL_W-1] ^ div_neg_q;
	assign div_req.num_zero = (v_sel == '0);

	sel_div #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_mag_q),
		.rsp    (div_rsp),
		.res    (div_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sel_pkg::S_IDLE: if (accept) state_d = sel_pkg::S_LIM;
			sel_pkg::S_LIM:  state_d = sel_pkg::S_GAIN;
			sel_pkg::S_GAIN: state_d = sel_pkg::S_GRND;
			sel_pkg::S_GRND: state_d = sel_pkg::S_V0;
			sel_pkg::S_V0:   state_d = sel_pkg::S_V1;
			sel_pkg::S_V1:   state_d = sel_pkg::S_V1R;
			sel_pkg::S_V1R:  state_d = sel_pkg::S_PEAK;
			sel_pkg::S_PEAK: state_d = sel_pkg::S_EMUL;
			sel_pkg::S_EMUL: state_d = sel_pkg::S_ENV;
			sel_pkg::S_ENV:  state_d = sel_pkg::S_ABS;
			sel_pkg::S_ABS:  state_d = sel_pkg::S_SEL;
			sel_pkg::S_SEL:  state_d = big_c ? sel_pkg::S_DLGO : sel_pkg::S_PASS;
			sel_pkg::S_PASS: state_d = sel_pkg::S_OUT;
			sel_pkg::S_DLGO: state_d = sel_pkg::S_DLW;
			sel_pkg::S_DLW:  if (div_rsp.done) state_d = sel_pkg::S_DRGO;
			sel_pkg::S_DRGO: state_d = sel_pkg::S_DRW;
			sel_pkg::S_DRW:  if (div_rsp.done) state_d = sel_pkg::S_OUT;
			sel_pkg::S_OUT:  if (out_free) state_d = sel_pkg::S_IDLE;
			default:         state_d = sel_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sel_pkg::S_IDLE;
			m_valid_q <= 1'b0;
			env_q     <= '0;
			volume_q  <= sel_pkg::VOLUME_RST;
			attack_q  <= sel_pkg::ATTACK_RST;
			release_q <= sel_pkg::RELEASE_RST;
		end else begin
			state_q <= state_d;
			if (state_q == sel_pkg::S_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == sel_pkg::S_ENV) begin
				env_q <= env_c;
			end
			if (cfg_we) begin
				case (cfg_idx)
					sel_pkg::REG_VOLUME:  volume_q  <= cfg_data;
					sel_pkg::REG_ATTACK:  attack_q  <= cfg_data;
					sel_pkg::REG_RELEASE: release_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s0_q   <= s_tdata[SB-1:0];
			s1_q   <= s_tdata[2*SB-1:SB];
			clip_q <= 1'b0;
		end
		case (state_q)
			sel_pkg::S_GAIN: limit_q <= prod_q[sel_pkg::LIM_W-1:0];
			sel_pkg::S_GRND: gain_q <= gain_c;
			sel_pkg::S_V1:   v0_q <= v_c;
			sel_pkg::S_V1R:  v1_q <= v_c;
			sel_pkg::S_PEAK: begin
				peak_q <= peak_c;
				coef_q <= (peak_c > env_q) ? attack_q : release_q;
				d_q    <= sel_pkg::DIFF_W'(env_q) - sel_pkg::DIFF_W'(peak_c);
			end
			sel_pkg::S_ABS: begin
				abs_q <= env_q[sel_pkg::ENV_W-1] ? -sel_pkg::DIFF_W'(env_q)
					: sel_pkg::DIFF_W'(env_q);
			end
			sel_pkg::S_SEL: begin
				div_neg_q <= divisor[sel_pkg::DIFF_W];
				div_mag_q <= divisor[sel_pkg::DIFF_W] ? sel_pkg::DIV_D_W'(-divisor)
					: divisor[sel_pkg::DIV_D_W-1:0];
			end
			sel_pkg::S_PASS: begin
				o0_q   <= p0_c[SB-1:0];
				o1_q   <= p1_c[SB-1:0];
				clip_q <= p0_c[SB] | p1_c[SB];
			end
			sel_pkg::S_DLW: begin
				if (div_rsp.done) begin
					o0_q   <= div_res;
					clip_q <= clip_q | div_rsp.clip;
				end
			end
			sel_pkg::S_DRW: begin
				if (div_rsp.done) begin
					o1_q   <= div_res;
					clip_q <= clip_q | div_rsp.clip;
				end
			end
			sel_pkg::S_OUT: begin
				if (out_free) begin
					out_l_q    <= o0_q;
					out_r_q    <= o1_q;
					out_clip_q <= clip_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/sel_chk.sv -----
module sel_chk #(
	parameter int SAMPLE_BITS = sel_pkg::SAMPLE_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	// left_out, right_out
	input logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	// clipped
	input logic                               m_tuser
);

	localparam int SB = SAMPLE_BITS;
	localparam logic [SB-1:0] OUT_HI = {1'b0, {(SB - 1){1'b1}}};
	localparam logic [SB-1:0] OUT_LO = {1'b1, {(SB - 1){1'b0}}};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while previous one in progress");

	a_result_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready && !$past(s_tready))
		else $error("result without a finished item");

	a_clip_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			(m_tdata[SB-1:0] == OUT_HI) || (m_tdata[SB-1:0] == OUT_LO)
			|| (m_tdata[2*SB-1:SB] == OUT_HI) || (m_tdata[2*SB-1:SB] == OUT_LO))
		else $error("clip flag without a saturated sample");

endmodule

bind stereo_envelope_limiter sel_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_sel_chk (.*);

// ----- dv/testbench.sv -----
module testbench;

	localparam int SB = sel_pkg::SAMPLE_BITS_DEF;
	localparam int DW = ((2*SB+7)/8)*8;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [sel_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [sel_pkg::CFG_W-1:0] FINAL_COEF = 16'd61440;
	localparam longint ONE30 = longint'(1) << 30;

	typedef enum int {
		MIX_FULL,
		MIX_LOUD_NEG,
		MIX_LOUD_POS,
		MIX_QUIET,
		MIX_EDGES
	} mix_t;

	typedef struct packed {
		logic signed [SB-1:0] left_out;
		logic signed [SB-1:0] right_out;
		logic                 clipped;
	} limited_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [DW-1:0]                 s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [DW-1:0]                 m_tdata;
	logic                          m_tuser;
	logic                          cfg_we = 1'b0;
	logic [sel_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [sel_pkg::CFG_W-1:0]     cfg_data = '0;

	// mirror of the block's registers and envelope
	logic [sel_pkg::CFG_W-1:0] vol_reg = sel_pkg::VOLUME_RST;
	logic [sel_pkg::CFG_W-1:0] atk_reg = sel_pkg::ATTACK_RST;
	logic [sel_pkg::CFG_W-1:0] rel_reg = sel_pkg::RELEASE_RST;
	longint                    env_st = 0;

	limited_t queued_pairs[$];
	bit       in_gaps = 1'b1;
	bit       rx_gaps = 1'b1;
	int       hold_cycles = 0;
	int       cycle_count = 0;
	int       err_count = 0;
	int       n_sent = 0;
	int       n_checked = 0;
	int       n_clip = 0;
	int       n_divided = 0;

	stereo_envelope_limiter #(
		.SAMPLE_BITS(SB)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("stereo_envelope_limiter: mismatch");
			$finish;
		end
	end

	// floor of x / 2^s plus one half
	function automatic longint rnd_shr(input longint x, input int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint limit_for(input logic [sel_pkg::CFG_W-1:0] vol);
		longint vv;
		vv = (vol > sel_pkg::VOL_MAX) ? longint'(sel_pkg::VOL_MAX) : longint'(vol);
		return vv * vv;
	endfunction

	function automatic longint gain_for(input logic [sel_pkg::CFG_W-1:0] vol);
		return rnd_shr(limit_for(vol) * longint'(sel_pkg::GAIN_095), 16);
	endfunction

	function automatic longint scale_by(input logic signed [SB-1:0] s, input longint g);
		return rnd_shr(longint'(s) * g, SB - 1);
	endfunction

	function automatic longint env_update(input longint env, input longint peak,
			input longint coef);
		longint e;
		e = rnd_shr(coef * (env - peak), sel_pkg::COEF_SHIFT) + peak;
		if (e > 64'sd2147483647)
			e = 64'sd2147483647;
		if (e < -64'sd2147483648)
			e = -64'sd2147483648;
		return e;
	endfunction

	// clip flag in the top bit
	function automatic logic [SB:0] sat16(input longint v);
		if (v > 32767)
			return {1'b1, 16'h7fff};
		if (v < -32768)
			return {1'b1, 16'h8000};
		return {1'b0, v[SB-1:0]};
	endfunction

	function automatic logic [SB:0] quot16(input longint v, input longint d);
		longint num;
		num = v * 32768;
		if (d == 0) begin
			if (num == 0)
				return '0;
			return (num > 0) ? {1'b1, 16'h7fff} : {1'b1, 16'h8000};
		end
		return sat16(num / d);
	endfunction

	function automatic limited_t limited_pair(input logic signed [SB-1:0] l,
			input logic signed [SB-1:0] r);
		limited_t res;
		longint   lim, g, v0, v1, pk, e, ea, dv;
		logic [SB:0] a, b;
		lim = limit_for(vol_reg);
		g = gain_for(vol_reg);
		v0 = scale_by(l, g);
		v1 = scale_by(r, g);
		pk = (v0 > v1) ? v0 : v1;
		e = env_update(env_st, pk, (pk > env_st) ? longint'(atk_reg) : longint'(rel_reg));
		env_st = e;
		ea = (e < 0) ? -e : e;
		if (ea > lim) begin
			dv = (ea > ONE30) ? e : ONE30 + e - lim;
			a = quot16(v0, dv);
			b = quot16(v1, dv);
			n_divided++;
		end else begin
			a = sat16(rnd_shr(v0 * 32768, sel_pkg::Q30_SHIFT));
			b = sat16(rnd_shr(v1 * 32768, sel_pkg::Q30_SHIFT));
		end
		res.left_out = a[SB-1:0];
		res.right_out = b[SB-1:0];
		res.clipped = a[SB] | b[SB];
		return res;
	endfunction

	function automatic logic [sel_pkg::CFG_W-1:0] pick_coef();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom);
			default: return 16'($urandom_range(60000, 65535));
		endcase
	endfunction

	function automatic logic signed [SB-1:0] rand_sample(input mix_t mix);
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		case (mix)
			MIX_LOUD_NEG: return 16'(-int'($urandom_range(16384, 32768)));
			MIX_LOUD_POS: return 16'($urandom_range(16384, 32767));
			MIX_QUIET:    return 16'(int'($urandom_range(0, 511)) - 256);
			MIX_EDGES: begin
				case ($urandom_range(0, 4))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		int gap;
		gap = in_gaps ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r, l};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		queued_pairs.push_back(limited_pair(l, r));
		n_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (queued_pairs.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [sel_pkg::CFG_IDX_W-1:0] idx,
			input logic [sel_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			sel_pkg::REG_VOLUME:  vol_reg = val;
			sel_pkg::REG_ATTACK:  atk_reg = val;
			sel_pkg::REG_RELEASE: rel_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [sel_pkg::CFG_W-1:0] vol,
			input logic [sel_pkg::CFG_W-1:0] atk, input logic [sel_pkg::CFG_W-1:0] rel);
		write_reg(sel_pkg::REG_VOLUME, vol);
		write_reg(sel_pkg::REG_ATTACK, atk);
		write_reg(sel_pkg::REG_RELEASE, rel);
	endtask

	task automatic test_extremes();
		send_pair(16'sd0, 16'sd0);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(16'sd1, -16'sd1);
	endtask

	task automatic test_volume_range();
		wait_idle();
		set_config(16'd0, 16'd0, 16'hffff);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		wait_idle();
		set_config(sel_pkg::VOL_MAX, 16'hffff, 16'd0);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sd0, 16'sd0);
		// volume above one, envelope driven far negative
		wait_idle();
		set_config(16'hffff, 16'd0, 16'd0);
		send_pair(16'sh7fff, 16'sd1234);
		send_pair(16'sh8000, 16'sh8000);
		// volume drop leaves a negative envelope above the limit
		wait_idle();
		set_config(16'd8000, 16'hffff, 16'hffff);
		send_pair(16'sd1000, -16'sd1000);
		send_pair(16'sh7fff, 16'sh8000);
		wait_idle();
		set_config(sel_pkg::VOL_MAX, 16'd0, 16'd0);
		send_pair(16'sh7fff, 16'sh7fff);
		wait_idle();
		set_config(16'd8000, 16'hffff, 16'hffff);
		send_pair(16'sh7fff, 16'sh8000);
	endtask

	// steer the envelope onto limit - 1.0 so that the divisor is zero
	task automatic test_zero_divisor();
		longint gt, gfull, tgt, pk, e_need, e0, p0, guess;
		int     sa, c_found;
		logic signed [SB-1:0] ls, rs;
		bit     ok;
		gfull = gain_for(sel_pkg::VOL_MAX);
		gt = gain_for(16'd16384);
		tgt = limit_for(16'd16384) - ONE30;
		for (int k = 0; k < 2; k++) begin
			ls = (k == 0) ? 16'sd0 : 16'sd1200;
			rs = -16'sd1000;
			pk = scale_by(ls, gt);
			if (scale_by(rs, gt) > pk)
				pk = scale_by(rs, gt);
			ok = 1'b0;
			e_need = 0;
			guess = pk + ((tgt - pk) * 65536) / longint'(FINAL_COEF);
			for (longint e = guess - 4; e <= guess + 4; e++)
				if (!ok && env_update(e, pk, longint'(FINAL_COEF)) == tgt) begin
					e_need = e;
					ok = 1'b1;
				end
			sa = -32768;
			while (sa < 32766 && scale_by(16'(sa + 1), gfull) < e_need)
				sa++;
			e0 = scale_by(16'(sa), gfull);
			p0 = scale_by(16'(sa + 1), gfull);
			c_found = -1;
			for (int c = 0; c < 65536; c++)
				if (c_found < 0 && env_update(e0, p0, c) == e_need)
					c_found = c;
			if (ok && c_found >= 0) begin
				wait_idle();
				set_config(sel_pkg::VOL_MAX, 16'd0, 16'd0);
				send_pair(16'(sa), 16'(sa));
				wait_idle();
				set_config(sel_pkg::VOL_MAX, 16'(c_found), 16'(c_found));
				send_pair(16'(sa + 1), 16'(sa + 1));
				wait_idle();
				set_config(16'd16384, FINAL_COEF, FINAL_COEF);
				send_pair(ls, rs);
			end
		end
	endtask

	task automatic test_output_stall();
		wait_idle();
		in_gaps = 1'b0;
		hold_cycles = 400;
		repeat (12) send_pair(16'($urandom), 16'($urandom));
		in_gaps = 1'b1;
	endtask

	task automatic test_random_phases();
		logic [sel_pkg::CFG_W-1:0] vol;
		mix_t mix;
		for (int ph = 0; ph < 12; ph++) begin
			wait_idle();
			if (ph % 2 == 0) begin
				case ($urandom_range(0, 5))
					0: vol = 16'd0;
					1: vol = sel_pkg::VOL_MAX;
					2: vol = 16'hffff;
					3: vol = 16'($urandom);
					default: vol = 16'($urandom_range(16000, 32768));
				endcase
			end else begin
				vol = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1500, 20000));
			end
			set_config(vol, pick_coef(), pick_coef());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, 16'($urandom));
			in_gaps = (ph == 3) ? 1'b0 : 1'($urandom_range(0, 1));
			rx_gaps = (ph == 3) ? 1'b0 : 1'($urandom_range(0, 1));
			mix = mix_t'($urandom_range(0, 4));
			repeat (50) send_pair(rand_sample(mix), rand_sample(mix));
		end
		in_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	initial begin : result_check
		int       stall;
		limited_t got, want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = rx_gaps ? $urandom_range(0, 17) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got.left_out = m_tdata[SB-1:0];
			got.right_out = m_tdata[2*SB-1:SB];
			got.clipped = m_tuser;
			n_checked++;
			if (got.clipped)
				n_clip++;
			if (queued_pairs.size() == 0) begin
				$error("result with no item pending: left_out %0d right_out %0d clipped %0d",
					got.left_out, got.right_out, got.clipped);
				err_count++;
			end else begin
				want = queued_pairs.pop_front();
				if (got.left_out !== want.left_out) begin
					$error("left_out expected %0d actual %0d", want.left_out, got.left_out);
					err_count++;
				end
				if (got.right_out !== want.right_out) begin
					$error("right_out expected %0d actual %0d", want.right_out, got.right_out);
					err_count++;
				end
				if (got.clipped !== want.clipped) begin
					$error("clipped expected %0d actual %0d", want.clipped, got.clipped);
					err_count++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_volume_range();
		test_zero_divisor();
		test_output_stall();
		test_random_phases();
		wait_idle();
		repeat (60) @(posedge clk);
		$display("%0d sample pairs sent, %0d results checked, %0d errors", n_sent, n_checked,
			err_count);
		$display("%0d pairs took the divider path, %0d results flagged as clipped", n_divided,
			n_clip);
		if (err_count == 0 && queued_pairs.size() == 0)
			$display("stereo_envelope_limiter: match");
		else
			$display("stereo_envelope_limiter: mismatch");
		$finish;
	end

endmodule
